// ----- rtl/vector_clock_table_core_macros.svh -----
// Assertion macros shared by the vector clock table RTL
`ifndef VECTOR_CLOCK_TABLE_CORE_MACROS_SVH
`define VECTOR_CLOCK_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define VCT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication, disabled during reset
`define VCT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`else

`define VCT_ASSERT_IMP(label, clk, rst, ante, cons)
`define VCT_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/vct_pkg.sv -----
package vct_pkg;

   // Table geometry
   localparam int ENTRIES = 16;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   // Field widths
   localparam int CMD_W  = 3;
   localparam int KEY_W  = 16;
   localparam int TIME_W = 64;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SET   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FIND  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_MERGE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_MAX   = 3'd4;

   // Time step for tick
   localparam logic [TIME_W-1:0] TIME_STEP = 64'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_RESP
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic             load;
      logic             read_en;
      logic [IDX_W-1:0] rd_addr;
      logic             update;
   } vct_cmd_type;

endpackage

// ----- rtl/vct_ctrl.sv -----
`include "vector_clock_table_core_macros.svh"

module vct_ctrl
   import vct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output vct_cmd_type cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] scan_ff, scan_in;

   // State and scan counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      scan_in     = scan_ff;
      cmd.load    = 1'b0;
      cmd.read_en = 1'b0;
      cmd.rd_addr = scan_ff[IDX_W-1:0];
      cmd.update  = 1'b0;
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               scan_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue one read per cycle, then wait for the last compare
            if (scan_ff < CNT_W'(ENTRIES)) begin
               cmd.read_en = 1'b1;
               scan_in     = scan_ff + CNT_W'(1);
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `VCT_ASSERT_NXT(a_accept_starts_scan, clock, reset, req_valid && !req_stall, state_ff == ST_SCAN && scan_ff == '0)
   `VCT_ASSERT_IMP(a_scan_bounded, clock, reset, 1'b1, scan_ff <= CNT_W'(ENTRIES))

endmodule

// ----- rtl/vct_datapath.sv -----
`include "vector_clock_table_core_macros.svh"

module vct_datapath
   import vct_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  vct_cmd_type       cmd,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [KEY_W-1:0]  req_key,
   input  logic [TIME_W-1:0] req_value,
   output logic [TIME_W-1:0] rsp_time_res,
   output logic              rsp_found,
   output logic              rsp_table_full
);

   // Entry storage
   logic [KEY_W-1:0]  key_mem  [ENTRIES];
   logic [TIME_W-1:0] time_mem [ENTRIES];

   // Latched request
   logic [CMD_W-1:0]  op_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [TIME_W-1:0] value_ff;

   // Read stage
   logic              rd_vld_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic [KEY_W-1:0]  rd_key_ff;
   logic [TIME_W-1:0] rd_time_ff;

   // Scan results
   logic              hit_ff;
   logic [IDX_W-1:0]  hit_idx_ff;
   logic [TIME_W-1:0] hit_time_ff;
   logic [TIME_W-1:0] max_ff;
   logic [CNT_W-1:0]  count_ff, count_in;

   // Result registers
   logic [TIME_W-1:0] res_ff, res_in;
   logic              fnd_ff, fnd_in;
   logic              full_ff, full_in;

   // Write port
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [TIME_W-1:0] wr_time;

   logic              ent_ok;
   logic              is_full;

   assign ent_ok  = CNT_W'(rd_idx_ff) < count_ff;
   assign is_full = count_ff == CNT_W'(ENTRIES);

   // Latch the request on transfer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_command;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
   end

   // Memory read, registered
   always_ff @(posedge clock) begin
      if (cmd.read_en) begin
         rd_key_ff  <= key_mem[cmd.rd_addr];
         rd_time_ff <= time_mem[cmd.rd_addr];
      end
      rd_idx_ff <= cmd.rd_addr;
   end

   // Memory write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]  <= key_ff;
         time_mem[wr_addr] <= wr_time;
      end
   end

   // Control state: read valid, hit flag, fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         hit_ff    <= 1'b0;
         count_ff  <= '0;
      end else begin
         rd_vld_ff <= cmd.read_en;
         count_ff  <= count_in;
         if (cmd.load) begin
            hit_ff <= 1'b0;
         end else if (rd_vld_ff && ent_ok && rd_key_ff == key_ff) begin
            hit_ff <= 1'b1;
         end
      end
   end

   // Compare each read entry against key and running maximum
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         max_ff <= req_value;
      end else if (rd_vld_ff && ent_ok) begin
         if (rd_key_ff == key_ff && !hit_ff) begin
            hit_idx_ff  <= rd_idx_ff;
            hit_time_ff <= rd_time_ff;
         end
         if (rd_time_ff > max_ff) begin
            max_ff <= rd_time_ff;
         end
      end
   end

   // Decide the write-back and the result
   always_comb begin
      res_in   = '0;
      fnd_in   = 1'b0;
      full_in  = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = hit_idx_ff;
      wr_time  = hit_time_ff;
      count_in = count_ff;
      case (op_ff)
         CMD_MAX: begin
            res_in = max_ff;
         end
         CMD_TICK, CMD_SET, CMD_FIND, CMD_MERGE: begin
            if (hit_ff) begin
               fnd_in = 1'b1;
               case (op_ff)
                  CMD_TICK:  wr_time = hit_time_ff + TIME_STEP;
                  CMD_SET:   wr_time = value_ff;
                  CMD_MERGE: wr_time = (hit_time_ff < value_ff) ? value_ff : hit_time_ff;
                  default:   wr_time = hit_time_ff;
               endcase
               wr_en  = cmd.update && op_ff != CMD_FIND;
               res_in = wr_time;
            end else if (op_ff != CMD_FIND) begin
               if (is_full) begin
                  full_in = 1'b1;
               end else begin
                  // insert at the lowest free entry
                  wr_addr = count_ff[IDX_W-1:0];
                  wr_time = (op_ff == CMD_TICK) ? TIME_STEP : value_ff;
                  wr_en   = cmd.update;
                  res_in  = wr_time;
                  if (cmd.update) begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end
            end
         end
         default: begin
            res_in = '0;
         end
      endcase
   end

   // Result registers, held while the response waits
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         res_ff  <= res_in;
         fnd_ff  <= fnd_in;
         full_ff <= full_in;
      end
   end

   assign rsp_time_res   = res_ff;
   assign rsp_found      = fnd_ff;
   assign rsp_table_full = full_ff;

   `VCT_ASSERT_IMP(a_count_bounded, clock, reset, 1'b1, count_ff <= CNT_W'(ENTRIES))
   `VCT_ASSERT_NXT(a_full_keeps_count, clock, reset, cmd.update && full_in, $stable(count_ff))
   `VCT_ASSERT_NXT(a_flags_exclusive, clock, reset, cmd.update, !(fnd_ff && full_ff))
   `VCT_ASSERT_IMP(a_count_only_on_update, clock, reset, !cmd.update, count_in == count_ff)

endmodule

// ----- rtl/vector_clock_table_core.sv -----
// The table is scanned one entry per cycle through the registered memory read port,
// followed by a compare-drain step, a write-back step and the response step.
// One item is in flight at a time, and rsp_stall can hold the response.
// Reset (synchronous, active high) empties the table by clearing the fill count;
// entry storage is not cleared, and entries above the fill count are never used.
module vector_clock_table_core
   import vct_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [KEY_W-1:0]  req_key,
   input  logic [TIME_W-1:0] req_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [TIME_W-1:0] rsp_time_res,
   output logic              rsp_found,
   output logic              rsp_table_full
);

   vct_cmd_type cmd;

   vct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   vct_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_command    (req_command),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_time_res   (rsp_time_res),
      .rsp_found      (rsp_found),
      .rsp_table_full (rsp_table_full)
   );

endmodule
